>>> rtl/core/json_string_unescape_utf8_top_defines.svh
// Assertion macros used by the RTL top level.
`ifndef JSON_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_SAME(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> rtl/core/jsu_pkg.sv
package jsu_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  kind;
    logic [2:0]  error_code;
    logic [15:0] out_length;
    logic        last_of_run;
  } res_t;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_UNTERMINATED = 3'd1;
  localparam logic [2:0] ERR_TRUNC_ESC    = 3'd2;
  localparam logic [2:0] ERR_TRUNC_U      = 3'd3;
  localparam logic [2:0] ERR_BAD_U        = 3'd4;
  localparam logic [2:0] ERR_UNKNOWN_ESC  = 3'd5;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  localparam logic [15:0] SURR_HI_FIRST = 16'hD800;
  localparam logic [15:0] SURR_HI_LAST  = 16'hDBFF;
  localparam logic [15:0] SURR_LO_FIRST = 16'hDC00;
  localparam logic [15:0] SURR_LO_LAST  = 16'hDFFF;
  localparam logic [20:0] CP_PAIR_BASE  = 21'h10000;
  localparam logic [20:0] CP_REPLACE    = 21'h00FFFD;

  // Results of one input beat: leading data bytes, then an optional end or error.
  localparam int BATCH_SLOTS = 6;

  typedef enum logic [2:0] {
    MODE_NORMAL   = 3'd0,
    MODE_ESC      = 3'd1,
    MODE_HEX      = 3'd2,
    MODE_PAIR_BSL = 3'd3,
    MODE_PAIR_U   = 3'd4,
    MODE_PAIR_HEX = 3'd5
  } mode_t;

  typedef struct packed {
    logic [BATCH_SLOTS-1:0][7:0] bytes;
    logic [2:0]                  n_data;
    logic [2:0]                  n_res;
    logic [1:0]                  term_kind;
    logic [2:0]                  term_code;
    logic [15:0]                 term_length;
  } batch_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      n;
  } utf8_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t u;
    u = '0;
    if (cp < 21'h80) begin
      u.bytes[0] = {1'b0, cp[6:0]};
      u.n = 3'd1;
    end else if (cp < 21'h800) begin
      u.bytes[0] = {3'b110, cp[10:6]};
      u.bytes[1] = {2'b10, cp[5:0]};
      u.n = 3'd2;
    end else if (cp < 21'h10000) begin
      u.bytes[0] = {4'b1110, cp[15:12]};
      u.bytes[1] = {2'b10, cp[11:6]};
      u.bytes[2] = {2'b10, cp[5:0]};
      u.n = 3'd3;
    end else begin
      u.bytes[0] = {5'b11110, cp[20:18]};
      u.bytes[1] = {2'b10, cp[17:12]};
      u.bytes[2] = {2'b10, cp[11:6]};
      u.bytes[3] = {2'b10, cp[5:0]};
      u.n = 3'd4;
    end
    return u;
  endfunction

  function automatic hex_t hex_digit(input logic [7:0] b);
    hex_t h;
    h = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.ok = 1'b1;
      h.val = b[3:0];
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      h.ok = 1'b1;
      h.val = 4'(b[2:0] + 3'd1) + 4'd8;
    end
    return h;
  endfunction

endpackage

>>> rtl/core/json_string_unescape_utf8_top.sv
// Channel  Signals                          Beat
// text     text_valid text_ready text       one raw byte or end of text
// res      res_valid  res_ready  res        one decoded byte, end or error
//
// Each text beat is decoded into a batch of zero to six results.
// The result buffer drains a beat per cycle unless res stalls, so a beat with n
// results blocks text until the last leaves; beats with n <= 1 flow every cycle.
// Reset (rst, synchronous) returns the decoder to plain text with zero length.
// A stall on res holds the buffer and blocks text until its last beat leaves.
`include "json_string_unescape_utf8_top_defines.svh"

module json_string_unescape_utf8_top
  import jsu_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  text_valid,
  output logic  text_ready,
  input  text_t text,
  output logic  res_valid,
  input  logic  res_ready,
  output res_t  res
);

  logic   accept;
  batch_t batch;

  assign accept = text_valid && text_ready;

  jsu_decode #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_decode (
    .clk  (clk),
    .rst  (rst),
    .take (accept),
    .text (text),
    .batch(batch)
  );

  jsu_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .batch_in (batch),
    .can_load (text_ready),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  `ASSERT_SAME(a_empty_takes_text, clk, rst, !res_valid, text_ready)
  `ASSERT_SAME(a_stall_blocks_text, clk, rst, res_valid && !res_ready, !text_ready)
  `ASSERT_SAME(a_term_is_last, clk, rst, res_valid && res.kind != KIND_DATA, res.last_of_run)
  `ASSERT_NEXT(a_mid_batch_holds, clk, rst, res_valid && !res.last_of_run, res_valid)

endmodule

>>> rtl/core/jsu_decode.sv
module jsu_decode
  import jsu_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   take,
  input  text_t  text,
  output batch_t batch
);

  mode_t                  mode, mode_next;
  logic [1:0]             cnt, cnt_next;
  logic [15:0]            acc, acc_next;
  logic [15:0]            hs, hs_next;
  logic [LENGTH_BITS-1:0] len, len_next;

  hex_t        hx;
  logic [15:0] acc_shift;
  logic        hex_done;
  logic        esc_ok, esc_u;
  logic [7:0]  esc_val;
  logic        do_normal, do_escape;
  logic        pre;
  logic        main_raw_on, main_cp_on;
  logic [7:0]  main_raw;
  logic [20:0] main_cp;
  utf8_t       main_u, fffd;
  logic        term_on;
  logic [1:0]  term_kind;
  logic [2:0]  term_code;
  logic [2:0]  n_data;
  logic [LENGTH_BITS:0]   len_sum;
  logic [LENGTH_BITS-1:0] len_sat;
  logic [31:0] len_wide;

  always_comb begin
    hx        = hex_digit(text.text_byte);
    acc_shift = {acc[11:0], hx.val};
    hex_done  = (cnt == 2'd3);

    esc_ok  = 1'b1;
    esc_u   = 1'b0;
    esc_val = text.text_byte;
    case (text.text_byte)
      CH_QUOTE, CH_BSL, CH_SLASH: esc_val = text.text_byte;
      CH_B:    esc_val = 8'h08;
      CH_F:    esc_val = 8'h0C;
      CH_N:    esc_val = 8'h0A;
      CH_R:    esc_val = 8'h0D;
      CH_T:    esc_val = 8'h09;
      CH_U: begin
        esc_ok = 1'b0;
        esc_u  = 1'b1;
      end
      default: esc_ok = 1'b0;
    endcase

    mode_next   = mode;
    cnt_next    = cnt;
    acc_next    = acc;
    hs_next     = hs;
    do_normal   = 1'b0;
    do_escape   = 1'b0;
    pre         = 1'b0;
    main_raw_on = 1'b0;
    main_cp_on  = 1'b0;
    main_raw    = text.text_byte;
    main_cp     = '0;
    term_on     = 1'b0;
    term_kind   = KIND_DATA;
    term_code   = ERR_NONE;

    if (text.end_of_text) begin
      term_on   = 1'b1;
      term_kind = KIND_ERROR;
      unique case (mode)
        MODE_ESC:      term_code = ERR_TRUNC_ESC;
        MODE_HEX:      term_code = ERR_TRUNC_U;
        MODE_PAIR_BSL: begin
          pre = 1'b1;
          term_code = ERR_UNTERMINATED;
        end
        MODE_PAIR_U: begin
          pre = 1'b1;
          term_code = ERR_TRUNC_ESC;
        end
        MODE_PAIR_HEX: begin
          pre = 1'b1;
          term_code = ERR_TRUNC_U;
        end
        default:       term_code = ERR_UNTERMINATED;
      endcase
    end else begin
      unique case (mode)
        MODE_ESC: do_escape = 1'b1;
        MODE_HEX: begin
          if (!hx.ok) begin
            term_on   = 1'b1;
            term_kind = KIND_ERROR;
            term_code = ERR_BAD_U;
          end else begin
            acc_next = acc_shift;
            if (!hex_done) begin
              cnt_next = cnt + 2'd1;
            end else begin
              cnt_next = 2'd0;
              if (acc_shift >= SURR_HI_FIRST && acc_shift <= SURR_HI_LAST) begin
                hs_next   = acc_shift;
                mode_next = MODE_PAIR_BSL;
              end else begin
                main_cp_on = 1'b1;
                main_cp    = (acc_shift >= SURR_LO_FIRST && acc_shift <= SURR_LO_LAST) ?
                             CP_REPLACE : 21'(acc_shift);
                mode_next  = MODE_NORMAL;
              end
            end
          end
        end
        MODE_PAIR_BSL: begin
          if (text.text_byte == CH_BSL) begin
            mode_next = MODE_PAIR_U;
          end else begin
            pre       = 1'b1;
            do_normal = 1'b1;
          end
        end
        MODE_PAIR_U: begin
          if (text.text_byte == CH_U) begin
            mode_next = MODE_PAIR_HEX;
            cnt_next  = 2'd0;
            acc_next  = '0;
          end else begin
            pre       = 1'b1;
            do_escape = 1'b1;
          end
        end
        MODE_PAIR_HEX: begin
          if (!hx.ok) begin
            term_on   = 1'b1;
            term_kind = KIND_ERROR;
            term_code = ERR_BAD_U;
          end else begin
            acc_next = acc_shift;
            if (!hex_done) begin
              cnt_next = cnt + 2'd1;
            end else begin
              cnt_next = 2'd0;
              if (acc_shift >= SURR_LO_FIRST && acc_shift <= SURR_LO_LAST) begin
                // Join the pair: ten bits from each half above the base.
                main_cp_on = 1'b1;
                main_cp    = CP_PAIR_BASE + 21'({hs[9:0], acc_shift[9:0]});
                mode_next  = MODE_NORMAL;
              end else begin
                pre = 1'b1;
                if (acc_shift >= SURR_HI_FIRST && acc_shift <= SURR_HI_LAST) begin
                  hs_next   = acc_shift;
                  mode_next = MODE_PAIR_BSL;
                end else begin
                  main_cp_on = 1'b1;
                  main_cp    = 21'(acc_shift);
                  mode_next  = MODE_NORMAL;
                end
              end
            end
          end
        end
        default: do_normal = 1'b1;
      endcase
    end

    if (do_normal) begin
      mode_next = MODE_NORMAL;
      if (text.text_byte == CH_QUOTE) begin
        term_on   = 1'b1;
        term_kind = KIND_END;
      end else if (text.text_byte == CH_BSL) begin
        mode_next = MODE_ESC;
      end else begin
        main_raw_on = 1'b1;
      end
    end

    if (do_escape) begin
      if (esc_ok) begin
        main_raw_on = 1'b1;
        main_raw    = esc_val;
        mode_next   = MODE_NORMAL;
      end else if (esc_u) begin
        mode_next = MODE_HEX;
        cnt_next  = 2'd0;
        acc_next  = '0;
      end else begin
        term_on   = 1'b1;
        term_kind = KIND_ERROR;
        term_code = ERR_UNKNOWN_ESC;
      end
    end

    if (main_raw_on) begin
      main_u = '0;
      main_u.bytes[0] = main_raw;
      main_u.n = 3'd1;
    end else if (main_cp_on) begin
      main_u = utf8_enc(main_cp);
    end else begin
      main_u = '0;
    end

    fffd = utf8_enc(CP_REPLACE);

    // Replacement bytes lead, then the main code point or byte.
    if (pre) begin
      batch.bytes = {main_u.bytes[2:0], fffd.bytes[2:0]};
    end else begin
      batch.bytes = {16'h0000, main_u.bytes};
    end
    n_data = (pre ? 3'd3 : 3'd0) + main_u.n;

    len_sum = {1'b0, len} + (LENGTH_BITS+1)'(n_data);
    len_sat = len_sum[LENGTH_BITS] ? '1 : len_sum[LENGTH_BITS-1:0];
    len_wide = 32'(len_sat);

    batch.n_data      = n_data;
    batch.n_res       = n_data + 3'(term_on);
    batch.term_kind   = term_kind;
    batch.term_code   = term_code;
    batch.term_length = (term_kind == KIND_END) ? len_wide[15:0] : 16'd0;

    // Finish or error starts a fresh string.
    if (term_on) begin
      mode_next = MODE_NORMAL;
      cnt_next  = '0;
      acc_next  = '0;
      hs_next   = '0;
      len_next  = '0;
    end else begin
      len_next  = len_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
      cnt  <= '0;
      acc  <= '0;
      hs   <= '0;
      len  <= '0;
    end else if (take) begin
      mode <= mode_next;
      cnt  <= cnt_next;
      acc  <= acc_next;
      hs   <= hs_next;
      len  <= len_next;
    end
  end

endmodule

>>> rtl/core/jsu_emit.sv
module jsu_emit
  import jsu_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   load,
  input  batch_t batch_in,
  output logic   can_load,
  output logic   res_valid,
  input  logic   res_ready,
  output res_t   res
);

  batch_t     batch;
  logic [2:0] count;
  logic [2:0] idx;
  logic       take;
  logic       is_data;

  assign res_valid = (idx != count);
  assign take      = res_valid && res_ready;
  // Refill when the buffer is empty or once the last beat of the held batch leaves.
  assign can_load  = (idx == count) || (take && (idx + 3'd1 == count));
  assign is_data   = (idx < batch.n_data);

  always_comb begin
    res.out_byte    = 8'h00;
    res.kind        = batch.term_kind;
    res.error_code  = batch.term_code;
    res.out_length  = batch.term_length;
    res.last_of_run = (idx + 3'd1 == count);
    if (is_data) begin
      res.out_byte   = batch.bytes[idx];
      res.kind       = KIND_DATA;
      res.error_code = ERR_NONE;
      res.out_length = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      batch <= batch_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else if (load) begin
      count <= batch_in.n_res;
      idx   <= '0;
    end else if (take) begin
      idx <= idx + 3'd1;
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import jsu_pkg::*;

  localparam int        CYCLE_LIMIT = 1_000_000;
  localparam int        RAND_BEATS  = 320;
  localparam logic [15:0] LEN_MAX   = 16'hFFFF;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_MOSTLY} rx_style_t;

  typedef struct {
    text_t beat;
    bit    typed;
    res_t  want;
  } dir_row_t;

  logic  clk        = 1'b0;
  logic  rst        = 1'b1;
  logic  text_valid = 1'b0;
  logic  text_ready;
  text_t text       = '0;
  logic  res_valid;
  logic  res_ready  = 1'b0;
  res_t  res;

  // typed expectation travels with the text beat
  bit    cur_typed = 1'b0;
  res_t  cur_want  = '0;

  // decoder model state
  mode_t       dec_mode  = MODE_NORMAL;
  logic [1:0]  digit_cnt = '0;
  logic [15:0] hex_acc   = '0;
  logic [15:0] hi_surr   = '0;
  logic [15:0] out_len   = '0;

  res_t     beat_res[$];
  res_t     decoded_q[$];
  text_t    body_q[$];
  dir_row_t dir_rows[$];

  int n_beats   = 0;
  int n_checked = 0;
  int n_end     = 0;
  int n_err     = 0;
  int fails     = 0;
  int burst_left = 0;
  int rx_phase   = 0;
  rx_style_t rx_style = RX_OPEN;
  res_t exp_r;

  json_string_unescape_utf8_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text       (text),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------- decoder model ----------------

  function automatic void clear_decoder();
    dec_mode  = MODE_NORMAL;
    digit_cnt = '0;
    hex_acc   = '0;
    hi_surr   = '0;
    out_len   = '0;
  endfunction

  function automatic void emit(input logic [7:0] b, input logic [1:0] k,
                               input logic [2:0] code, input logic [15:0] len);
    res_t r;
    r.out_byte    = b;
    r.kind        = k;
    r.error_code  = code;
    r.out_length  = len;
    r.last_of_run = 1'b0;
    beat_res.push_back(r);
  endfunction

  function automatic void emit_data(input logic [7:0] b);
    emit(b, KIND_DATA, ERR_NONE, '0);
    if (out_len != LEN_MAX) out_len = out_len + 16'd1;
  endfunction

  function automatic void emit_fail(input logic [2:0] code);
    emit('0, KIND_ERROR, code, '0);
    clear_decoder();
  endfunction

  function automatic void emit_utf8(input logic [20:0] cp);
    if (cp < 21'h80) begin
      emit_data({1'b0, cp[6:0]});
    end else if (cp < 21'h800) begin
      emit_data({3'b110, cp[10:6]});
      emit_data({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      emit_data({4'b1110, cp[15:12]});
      emit_data({2'b10, cp[11:6]});
      emit_data({2'b10, cp[5:0]});
    end else begin
      emit_data({5'b11110, cp[20:18]});
      emit_data({2'b10, cp[17:12]});
      emit_data({2'b10, cp[11:6]});
      emit_data({2'b10, cp[5:0]});
    end
  endfunction

  function automatic bit hex_nibble(input logic [7:0] b, output logic [3:0] v);
    v = '0;
    if (b >= "0" && b <= "9") begin
      v = 4'(b - 8'h30);
      return 1'b1;
    end
    if (b >= "a" && b <= "f") begin
      v = 4'(b - 8'h61 + 8'd10);
      return 1'b1;
    end
    if (b >= "A" && b <= "F") begin
      v = 4'(b - 8'h41 + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // true once the fourth digit is in
  function automatic bit take_hex(input logic [7:0] b);
    logic [3:0] v;
    if (!hex_nibble(b, v)) begin
      emit_fail(ERR_BAD_U);
      return 1'b0;
    end
    hex_acc = {hex_acc[11:0], v};
    if (digit_cnt == 2'd3) begin
      digit_cnt = '0;
      return 1'b1;
    end
    digit_cnt = digit_cnt + 2'd1;
    return 1'b0;
  endfunction

  function automatic void code_point(input logic [15:0] cp);
    if (cp >= SURR_HI_FIRST && cp <= SURR_HI_LAST) begin
      hi_surr  = cp;
      dec_mode = MODE_PAIR_BSL;
    end else begin
      if (cp >= SURR_LO_FIRST && cp <= SURR_LO_LAST) emit_utf8(CP_REPLACE);
      else emit_utf8({5'd0, cp});
      dec_mode = MODE_NORMAL;
    end
  endfunction

  function automatic void plain_text(input logic [7:0] b);
    if (b == CH_QUOTE) begin
      emit('0, KIND_END, ERR_NONE, out_len);
      clear_decoder();
    end else if (b == CH_BSL) begin
      dec_mode = MODE_ESC;
    end else begin
      emit_data(b);
    end
  endfunction

  function automatic void escape_char(input logic [7:0] b);
    logic [7:0] v;
    case (b)
      CH_QUOTE: v = CH_QUOTE;
      CH_BSL:   v = CH_BSL;
      CH_SLASH: v = CH_SLASH;
      CH_B:     v = 8'h08;
      CH_F:     v = 8'h0C;
      CH_N:     v = 8'h0A;
      CH_R:     v = 8'h0D;
      CH_T:     v = 8'h09;
      CH_U: begin
        dec_mode  = MODE_HEX;
        digit_cnt = '0;
        hex_acc   = '0;
        return;
      end
      default: begin
        emit_fail(ERR_UNKNOWN_ESC);
        return;
      end
    endcase
    emit_data(v);
    dec_mode = MODE_NORMAL;
  endfunction

  function automatic void decode_text_beat(input text_t beat, input bit typed,
                                           input res_t want);
    logic [7:0]  b;
    logic [15:0] lo;
    res_t        tail;
    b = beat.text_byte;
    beat_res.delete();
    if (beat.end_of_text) begin
      case (dec_mode)
        MODE_ESC:      emit_fail(ERR_TRUNC_ESC);
        MODE_HEX:      emit_fail(ERR_TRUNC_U);
        MODE_PAIR_BSL: begin emit_utf8(CP_REPLACE); emit_fail(ERR_UNTERMINATED); end
        MODE_PAIR_U:   begin emit_utf8(CP_REPLACE); emit_fail(ERR_TRUNC_ESC); end
        MODE_PAIR_HEX: begin emit_utf8(CP_REPLACE); emit_fail(ERR_TRUNC_U); end
        default:       emit_fail(ERR_UNTERMINATED);
      endcase
    end else begin
      case (dec_mode)
        MODE_ESC: escape_char(b);
        MODE_HEX: begin
          if (take_hex(b)) code_point(hex_acc);
        end
        MODE_PAIR_BSL: begin
          if (b == CH_BSL) begin
            dec_mode = MODE_PAIR_U;
          end else begin
            emit_utf8(CP_REPLACE);
            dec_mode = MODE_NORMAL;
            plain_text(b);
          end
        end
        MODE_PAIR_U: begin
          if (b == CH_U) begin
            dec_mode  = MODE_PAIR_HEX;
            digit_cnt = '0;
            hex_acc   = '0;
          end else begin
            emit_utf8(CP_REPLACE);
            escape_char(b);
          end
        end
        MODE_PAIR_HEX: begin
          if (take_hex(b)) begin
            lo = hex_acc;
            if (lo >= SURR_LO_FIRST && lo <= SURR_LO_LAST) begin
              emit_utf8(CP_PAIR_BASE + {1'b0, hi_surr[9:0], lo[9:0]});
              dec_mode = MODE_NORMAL;
            end else begin
              emit_utf8(CP_REPLACE);
              code_point(lo);
            end
          end
        end
        default: begin
          dec_mode = MODE_NORMAL;
          plain_text(b);
        end
      endcase
    end
    if (beat_res.size() > 0) begin
      tail = beat_res[beat_res.size()-1];
      tail.last_of_run = 1'b1;
      beat_res[beat_res.size()-1] = tail;
    end
    if (typed) decoded_q.push_back(want);
    else foreach (beat_res[i]) decoded_q.push_back(beat_res[i]);
  endfunction

  // ---------------- monitor and checker ----------------

  always @(posedge clk) begin
    if (!rst) begin
      if (text_valid && text_ready) begin
        decode_text_beat(text, cur_typed, cur_want);
        n_beats++;
      end
      if (res_valid && res_ready) begin
        n_checked++;
        if (res.kind == KIND_END) n_end++;
        if (res.kind == KIND_ERROR) n_err++;
        if (decoded_q.size() == 0) begin
          $error("unexpected result beat: kind %0d out_byte %02h", res.kind, res.out_byte);
          fails++;
        end else begin
          exp_r = decoded_q.pop_front();
          if (res.out_byte !== exp_r.out_byte) begin
            $error("out_byte: expected %02h, got %02h", exp_r.out_byte, res.out_byte);
            fails++;
          end
          if (res.kind !== exp_r.kind) begin
            $error("kind: expected %0d, got %0d", exp_r.kind, res.kind);
            fails++;
          end
          if (res.error_code !== exp_r.error_code) begin
            $error("error_code: expected %0d, got %0d", exp_r.error_code, res.error_code);
            fails++;
          end
          if (res.out_length !== exp_r.out_length) begin
            $error("out_length: expected %0d, got %0d", exp_r.out_length, res.out_length);
            fails++;
          end
          if (res.last_of_run !== exp_r.last_of_run) begin
            $error("last_of_run: expected %0d, got %0d", exp_r.last_of_run,
                   res.last_of_run);
            fails++;
          end
        end
      end
    end
  end

  // ---------------- receiver stalls ----------------

  always @(negedge clk) begin
    rx_phase = rx_phase + 1;
    if (rx_phase % 48 == 0) rx_style = rx_style_t'($urandom_range(0, 3));
    case (rx_style)
      RX_OPEN:     res_ready <= 1'b1;
      RX_COIN:     res_ready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: res_ready <= (rx_phase % 5) < 3;
      default:     res_ready <= ($urandom_range(0, 99) < 85);
    endcase
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // ---------------- stimulus helpers ----------------

  function automatic text_t mk_beat(input logic [7:0] b, input logic eot);
    text_t x;
    x.text_byte   = b;
    x.end_of_text = eot;
    return x;
  endfunction

  function automatic res_t mk_res(input logic [7:0] b, input logic [1:0] k,
                                  input logic [2:0] code, input logic [15:0] len);
    res_t r;
    r.out_byte    = b;
    r.kind        = k;
    r.error_code  = code;
    r.out_length  = len;
    r.last_of_run = 1'b1;
    return r;
  endfunction

  function automatic void dir_row(input text_t beat);
    dir_row_t row;
    row.beat  = beat;
    row.typed = 1'b0;
    row.want  = '0;
    dir_rows.push_back(row);
  endfunction

  function automatic void dir_typed(input text_t beat, input res_t want);
    dir_row_t row;
    row.beat  = beat;
    row.typed = 1'b1;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom);
    while (b == CH_QUOTE || b == CH_BSL) b = 8'($urandom);
    return b;
  endfunction

  function automatic logic [7:0] simple_esc();
    case ($urandom_range(0, 7))
      0: return CH_QUOTE;
      1: return CH_BSL;
      2: return CH_SLASH;
      3: return CH_B;
      4: return CH_F;
      5: return CH_N;
      6: return CH_R;
      default: return CH_T;
    endcase
  endfunction

  function automatic logic [7:0] bad_esc();
    logic [7:0] b;
    b = 8'($urandom);
    while (b == CH_QUOTE || b == CH_BSL || b == CH_SLASH || b == CH_B || b == CH_F ||
           b == CH_N || b == CH_R || b == CH_T || b == CH_U)
      b = 8'($urandom);
    return b;
  endfunction

  function automatic logic [7:0] bad_hex();
    logic [7:0] b;
    logic [3:0] v;
    b = 8'($urandom);
    while (hex_nibble(b, v)) b = 8'($urandom);
    return b;
  endfunction

  function automatic logic [15:0] rand_hi();
    return 16'($urandom_range(16'hD800, 16'hDBFF));
  endfunction

  function automatic logic [15:0] rand_lo();
    return 16'($urandom_range(16'hDC00, 16'hDFFF));
  endfunction

  function automatic logic [15:0] rand_cp();
    case ($urandom_range(0, 7))
      0: return 16'($urandom_range(0, 16'h7F));
      1: return 16'($urandom_range(16'h80, 16'h7FF));
      2: return 16'($urandom_range(16'h800, 16'hD7FF));
      3: return 16'($urandom_range(16'hE000, 16'hFFFF));
      4: return rand_hi();
      5: return rand_lo();
      6: return 16'($urandom);
      default: return $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
    endcase
  endfunction

  function automatic logic [15:0] rand_not_lo();
    logic [15:0] v;
    v = rand_cp();
    while (v >= SURR_LO_FIRST && v <= SURR_LO_LAST) v = rand_cp();
    return v;
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    body_q.push_back(mk_beat(b, 1'b0));
  endfunction

  function automatic void add_eot();
    body_q.push_back(mk_beat(8'($urandom), 1'b1));
  endfunction

  function automatic void add_uesc(input logic [15:0] v);
    add_byte(CH_BSL);
    add_byte(CH_U);
    for (int i = 3; i >= 0; i--) add_byte(hex_char(v[i*4 +: 4]));
  endfunction

  function automatic void add_partial_u(input int k);
    add_byte(CH_BSL);
    add_byte(CH_U);
    repeat (k) add_byte(hex_char(4'($urandom_range(0, 15))));
  endfunction

  // one string body: mostly well-formed tokens, then a closing quote or a break
  function automatic void build_body();
    int n_tok;
    int sel;
    bit done;
    body_q.delete();
    done  = 1'b0;
    n_tok = $urandom_range(0, 8);
    for (int t = 0; t < n_tok && !done; t++) begin
      sel = $urandom_range(0, 99);
      if (sel < 38) begin
        add_byte(plain_byte());
      end else if (sel < 52) begin
        add_byte(CH_BSL);
        add_byte(simple_esc());
      end else if (sel < 67) begin
        add_uesc(rand_cp());
      end else if (sel < 79) begin
        add_uesc(rand_hi());
        add_uesc(rand_lo());
      end else if (sel < 88) begin
        add_uesc(rand_hi());
        case ($urandom_range(0, 4))
          0: add_byte(plain_byte());
          1: begin add_byte(CH_BSL); add_byte(simple_esc()); end
          2: add_uesc(rand_not_lo());
          3: begin add_byte(CH_QUOTE); done = 1'b1; end
          default: begin add_byte(CH_BSL); add_byte(bad_esc()); done = 1'b1; end
        endcase
      end else if (sel < 94) begin
        done = 1'b1;
        case ($urandom_range(0, 2))
          0: begin add_byte(CH_BSL); add_byte(bad_esc()); end
          1: begin add_partial_u($urandom_range(0, 3)); add_byte(bad_hex()); end
          default: begin
            add_uesc(rand_hi());
            add_partial_u($urandom_range(0, 3));
            add_byte(bad_hex());
          end
        endcase
      end else begin
        done = 1'b1;
        case ($urandom_range(0, 4))
          0: add_byte(CH_BSL);
          1: add_partial_u($urandom_range(0, 3));
          2: add_uesc(rand_hi());
          3: begin add_uesc(rand_hi()); add_byte(CH_BSL); end
          default: begin add_uesc(rand_hi()); add_partial_u($urandom_range(0, 3)); end
        endcase
        add_eot();
      end
    end
    if (!done) begin
      if ($urandom_range(0, 9) < 8) add_byte(CH_QUOTE);
      else add_eot();
    end
  endfunction

  // drive one beat from a falling edge, return once it is taken and any idle gap ends
  task automatic send_beat(input text_t beat, input bit typed, input res_t want);
    int seen;
    seen = n_beats;
    text       <= beat;
    text_valid <= 1'b1;
    cur_typed  <= typed;
    cur_want   <= want;
    @(negedge clk);
    while (n_beats == seen) @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      text_valid <= 1'b0;
      text       <= text_t'($urandom);
      repeat ($urandom_range(1, 5)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(0, 24);
    end
  endtask

  // ---------------- main sequence ----------------

  initial begin
    int rand_beats;
    rand_beats = 0;
    clear_decoder();

    dir_typed(mk_beat(CH_QUOTE, 1'b0), mk_res('0, KIND_END, ERR_NONE, '0));
    dir_typed(mk_beat(8'hFF, 1'b1), mk_res('0, KIND_ERROR, ERR_UNTERMINATED, '0));
    dir_typed(mk_beat(8'h00, 1'b0), mk_res(8'h00, KIND_DATA, ERR_NONE, '0));
    dir_typed(mk_beat(8'hFF, 1'b0), mk_res(8'hFF, KIND_DATA, ERR_NONE, '0));
    dir_row(mk_beat(CH_BSL, 1'b0));
    dir_typed(mk_beat("q", 1'b0), mk_res('0, KIND_ERROR, ERR_UNKNOWN_ESC, '0));
    dir_row(mk_beat(CH_BSL, 1'b0));
    dir_typed(mk_beat(CH_N, 1'b0), mk_res(8'h0A, KIND_DATA, ERR_NONE, '0));
    // surrogate pair U+1F600
    dir_row(mk_beat(CH_BSL, 1'b0));
    dir_row(mk_beat(CH_U, 1'b0));
    dir_row(mk_beat("D", 1'b0));
    dir_row(mk_beat("8", 1'b0));
    dir_row(mk_beat("3", 1'b0));
    dir_row(mk_beat("D", 1'b0));
    dir_row(mk_beat(CH_BSL, 1'b0));
    dir_row(mk_beat(CH_U, 1'b0));
    dir_row(mk_beat("d", 1'b0));
    dir_row(mk_beat("E", 1'b0));
    dir_row(mk_beat("0", 1'b0));
    dir_row(mk_beat("0", 1'b0));
    dir_row(mk_beat(CH_QUOTE, 1'b0));
    dir_row(mk_beat(CH_BSL, 1'b0));
    dir_row(mk_beat(CH_U, 1'b0));
    dir_typed(mk_beat("g", 1'b0), mk_res('0, KIND_ERROR, ERR_BAD_U, '0));
    dir_row(mk_beat(CH_BSL, 1'b0));
    dir_typed(mk_beat(8'h00, 1'b1), mk_res('0, KIND_ERROR, ERR_TRUNC_ESC, '0));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

    while (rand_beats < RAND_BEATS) begin
      build_body();
      foreach (body_q[i]) send_beat(body_q[i], 1'b0, '0);
      rand_beats += body_q.size();
    end

    text_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d text beats (directed table, then random string bodies)",
             n_beats);
    $display("Checked %0d result beats: %0d string ends, %0d decode errors",
             n_checked, n_end, n_err);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/jsu_pkg.sv
rtl/core/jsu_decode.sv
rtl/core/jsu_emit.sv
rtl/core/json_string_unescape_utf8_top.sv
tb/testbench.sv
